// File: hdl/gf_pkg.sv
// ----------------------------------------------------------------------------
// gf_pkg
// Shared types, constants and table builders for the GF(2^8) arithmetic unit.
// ----------------------------------------------------------------------------
package gf_pkg;

  localparam logic [8:0] GF_POLY  = 9'h11d;
  localparam logic [8:0] GF_ORDER = 9'd255;

  typedef enum logic [1:0] {
    GF_OP_MUL = 2'd0,
    GF_OP_DIV = 2'd1,
    GF_OP_INV = 2'd2,
    GF_OP_POW = 2'd3
  } gf_op_t;

  typedef enum logic [1:0] {
    GF_RES_LOOKUP = 2'd0,
    GF_RES_ZERO   = 2'd1,
    GF_RES_ONE    = 2'd2
  } gf_res_kind_t;

  typedef logic [255:0][7:0] gf_table_t;

  typedef struct packed {
    gf_op_t      operation;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [15:0] exponent;
  } gf_in_t;

  typedef struct packed {
    logic [7:0] field_result;
    logic       zero_divisor;
  } gf_out_t;

  typedef struct packed {
    gf_op_t     operation;
    logic [7:0] log_a;
    logic [7:0] log_b;
    logic       a_zero;
    logic       b_zero;
    logic       e_zero;
    logic [7:0] e_mod;
  } gf_operands_t;

  typedef struct packed {
    gf_res_kind_t kind;
    logic         zero_div;
    logic [15:0]  log_sum;
  } gf_log_t;

  function automatic gf_table_t gf_build_exp();
    gf_table_t  t;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = x[7:0];
      x = x << 1;
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  function automatic gf_table_t gf_build_log();
    gf_table_t t;
    gf_table_t e;
    t = '0;
    e = gf_build_exp();
    for (int i = 0; i < 255; i++) begin
      t[e[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam gf_table_t GF_EXP = gf_build_exp();
  localparam gf_table_t GF_LOG = gf_build_log();

  // Reduction modulo 255 by folding bytes, since 256 is congruent to 1.
  function automatic logic [7:0] gf_mod255(input logic [15:0] x);
    logic [8:0] s;
    logic [7:0] t;
    s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
    t = s[7:0] + {7'd0, s[8]};
    return (t == 8'hff) ? 8'd0 : t;
  endfunction

endpackage

// File: hdl/gf_stream_if.sv
// ----------------------------------------------------------------------------
// gf_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface gf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/gf256_field_alu.sv
// ----------------------------------------------------------------------------
// gf256_field_alu
// A request beat is registered in the operand, log and result stages on its way to the response.
// Throughput is one beat per cycle while the response side is ready, set by three registered stages.
// Reset clears the stage valid flags only; the tables are constant ROMs.
// Multiply, divide, inverse and power over GF(2^8) with polynomial 0x11d.
// ----------------------------------------------------------------------------
module gf256_field_alu (
  input  logic          clk,
  input  logic          rst,
  gf_stream_if.sink     request,
  gf_stream_if.source   response
);
  import gf_pkg::*;

  logic         opnd_valid;
  logic         opnd_ready;
  gf_operands_t opnd_data;
  logic         log_valid;
  logic         log_ready;
  gf_log_t      log_data;
  gf_out_t      res_data;

  gf_operand_stage u_operand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .in_data   (request.data),
    .out_valid (opnd_valid),
    .out_ready (opnd_ready),
    .out_data  (opnd_data)
  );

  gf_log_stage u_log (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (opnd_valid),
    .in_ready  (opnd_ready),
    .in_data   (opnd_data),
    .out_valid (log_valid),
    .out_ready (log_ready),
    .out_data  (log_data)
  );

  gf_result_stage u_result (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (log_valid),
    .in_ready  (log_ready),
    .in_data   (log_data),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .out_data  (res_data)
  );

  assign response.data = res_data;

`ifndef SYNTH
  a_error_zero_result: assert property (@(posedge clk) disable iff (rst)
    response.valid && res_data.zero_divisor |-> res_data.field_result == 8'd0)
    else $error("zero divisor flag raised with a nonzero result");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    response.ready |-> request.ready)
    else $error("request stalled while the response side is ready");

  a_one_no_error: assert property (@(posedge clk) disable iff (rst)
    log_valid && log_data.kind == GF_RES_ONE |-> !log_data.zero_div)
    else $error("power result flagged as a zero divisor");
`endif
endmodule

// File: hdl/gf_operand_stage.sv
// ----------------------------------------------------------------------------
// gf_operand_stage
// Registers each request beat with its operand logarithms and reduced exponent.
// ----------------------------------------------------------------------------
module gf_operand_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gf_pkg::gf_in_t        in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gf_pkg::gf_operands_t  out_data
);
  import gf_pkg::*;

  logic         valid;
  gf_operands_t data;
  gf_operands_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.operation = in_data.operation;
    data_next.log_a     = GF_LOG[in_data.operand_a];
    data_next.log_b     = GF_LOG[in_data.operand_b];
    data_next.a_zero    = (in_data.operand_a == 8'd0);
    data_next.b_zero    = (in_data.operand_b == 8'd0);
    data_next.e_zero    = (in_data.exponent == 16'd0);
    data_next.e_mod     = gf_mod255(in_data.exponent);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end
endmodule

// File: hdl/gf_log_stage.sv
// ----------------------------------------------------------------------------
// gf_log_stage
// Combines operand logarithms per operation and flags the special cases.
// ----------------------------------------------------------------------------
module gf_log_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gf_pkg::gf_operands_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gf_pkg::gf_log_t      out_data
);
  import gf_pkg::*;

  logic    valid;
  gf_log_t data;
  gf_log_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.kind     = GF_RES_LOOKUP;
    data_next.zero_div = 1'b0;
    data_next.log_sum  = 16'd0;
    case (in_data.operation)
      GF_OP_MUL: begin
        data_next.log_sum = 16'(in_data.log_a) + 16'(in_data.log_b);
        if (in_data.a_zero || in_data.b_zero) begin
          data_next.kind = GF_RES_ZERO;
        end
      end
      GF_OP_DIV: begin
        data_next.log_sum = 16'(in_data.log_a) + 16'(GF_ORDER) - 16'(in_data.log_b);
        if (in_data.b_zero) begin
          data_next.kind     = GF_RES_ZERO;
          data_next.zero_div = 1'b1;
        end else if (in_data.a_zero) begin
          data_next.kind = GF_RES_ZERO;
        end
      end
      GF_OP_INV: begin
        data_next.log_sum = 16'(GF_ORDER) - 16'(in_data.log_a);
        if (in_data.a_zero) begin
          data_next.kind     = GF_RES_ZERO;
          data_next.zero_div = 1'b1;
        end
      end
      GF_OP_POW: begin
        data_next.log_sum = 16'(in_data.log_a) * 16'(in_data.e_mod);
        if (in_data.e_zero) begin
          data_next.kind = GF_RES_ONE;
        end else if (in_data.a_zero) begin
          data_next.kind = GF_RES_ZERO;
        end
      end
      default: begin
        data_next.kind = GF_RES_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end
endmodule

// File: hdl/gf_result_stage.sv
// ----------------------------------------------------------------------------
// gf_result_stage
// Reduces the combined logarithm, looks up the antilog and holds the result.
// ----------------------------------------------------------------------------
module gf_result_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gf_pkg::gf_log_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gf_pkg::gf_out_t  out_data
);
  import gf_pkg::*;

  logic    valid;
  gf_out_t data;
  gf_out_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.zero_divisor = in_data.zero_div;
    case (in_data.kind)
      GF_RES_LOOKUP: data_next.field_result = GF_EXP[gf_mod255(in_data.log_sum)];
      GF_RES_ONE:    data_next.field_result = 8'd1;
      default:       data_next.field_result = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end
endmodule
